// File: sv/assert_macros.svh
// Assertion macros shared by the min-tracking stack RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("min stack assertion failed (same cycle)");

// Next-cycle implication.
`define MTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("min stack assertion failed (next cycle)");

`endif

// File: sv/mts_pkg.sv
// Shared types and constants for the min-tracking stack.
// Used by mts_ram and min_tracking_stack_core; no dependencies.
package mts_pkg;

    localparam int STACK_DEPTH_DEFAULT = 64;
    localparam int DATA_W              = 32;
    localparam int ENTRY_W             = 34;
    localparam int FILL_W              = 7;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef enum logic
    {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        STAT_OK        = 2'd0,
        STAT_POP_EMPTY = 2'd1,
        STAT_PUSH_FULL = 2'd2
    } status_t;

    typedef logic signed [ENTRY_W-1:0] entry_t;

endpackage

// File: sv/min_tracking_stack_core.sv
// Top level of the min-tracking stack: input register, stack update and
// result register. Depends on mts_pkg, mts_ram and assert_macros.svh.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  --------+-----+-------------------------------------------------+--------------
//  s_*     | in  | value[31:0]                                     | action[0]
//  m_*     | out | top_value[31:0] min_value[31:0] is_empty fill_count[6:0] | status[1:0]
//
// One item per cycle sustained while the result side is not stalled; a result is
// valid once its input has passed the input register, then the result
// register. The rate holds because the top register, minimum register and
// count are all updated at the edge where an item fires.
// The entry below the top is prefetched from the RAM, so a pop needs no wait.
// Reset clears count and valid flags and sets the minimum to INT_MAX; the RAM is not cleared.
// A stalled result holds both stages; the input side keeps taking items
// while the input register can move forward.
`include "assert_macros.svh"

module min_tracking_stack_core #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [0:0]  s_tuser,   // action[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // top_value[31:0], min_value[63:32],
                                   // is_empty[64], fill_count[71:65]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = mts_pkg::DATA_W;
    localparam int EW = mts_pkg::ENTRY_W;

    // Input stage.
    logic                  in_valid_reg;
    mts_pkg::action_t      in_action_reg;
    logic signed [DW-1:0]  in_value_reg;

    // Stack state.
    logic [CW-1:0]         count_reg, count_next;
    logic signed [DW-1:0]  min_reg, min_next;
    mts_pkg::entry_t       top_reg, top_next;
    mts_pkg::entry_t       below_reg;
    logic                  below_sel_reg;

    // Result stage.
    logic                  out_valid_reg;
    logic [71:0]           out_data_reg, out_data_next;
    mts_pkg::status_t      out_status_reg, status_next;

    logic                  advance;
    logic                  fire;
    logic                  do_push;
    logic                  do_pop;
    mts_pkg::entry_t       below;
    mts_pkg::entry_t       x_ext;
    mts_pkg::entry_t       min_ext;
    mts_pkg::entry_t       min_next_ext;
    mts_pkg::entry_t       restored_min;
    mts_pkg::entry_t       marker;
    logic [CW-1:0]         count_m1;
    logic [CW-1:0]         count_m3;
    logic                  is_full;
    logic                  is_zero;
    logic signed [DW-1:0]  top_out;
    logic signed [DW-1:0]  min_out;
    mts_pkg::entry_t       ram_rd_data;

    function automatic logic [mts_pkg::FILL_W-1:0] FILL_W_CAST(input logic [CW-1:0] c);
        return mts_pkg::FILL_W'(c);
    endfunction

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_action_reg <= mts_pkg::action_t'(s_tuser[0]);
            in_value_reg  <= s_tdata;
        end
    end

    // The word below the top comes from the RAM after a pop, else from the
    // register that took the old top on the last push.
    assign below = below_sel_reg ? ram_rd_data : below_reg;

    assign x_ext        = {{(EW - DW){in_value_reg[DW-1]}}, in_value_reg};
    assign min_ext      = {{(EW - DW){min_reg[DW-1]}}, min_reg};
    assign marker       = {x_ext[EW-2:0], 1'b0} - min_ext;
    assign restored_min = {min_ext[EW-2:0], 1'b0} - top_reg;
    assign count_m1     = count_reg - CW'(1);
    assign count_m3     = count_reg - CW'(3);
    assign is_full      = (count_reg == CW'(STACK_DEPTH));
    assign is_zero      = (count_reg == '0);

    always_comb
    begin
        do_push     = 1'b0;
        do_pop      = 1'b0;
        count_next  = count_reg;
        min_next    = min_reg;
        top_next    = top_reg;
        status_next = mts_pkg::STAT_OK;
        case (in_action_reg)
            mts_pkg::ACT_PUSH:
            begin
                if (is_full)
                begin
                    status_next = mts_pkg::STAT_PUSH_FULL;
                end
                else
                begin
                    do_push    = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (is_zero)
                    begin
                        top_next = x_ext;
                        min_next = in_value_reg;
                    end
                    else if (x_ext >= min_ext)
                    begin
                        top_next = x_ext;
                    end
                    else
                    begin
                        top_next = marker;
                        min_next = in_value_reg;
                    end
                end
            end
            mts_pkg::ACT_POP:
            begin
                if (is_zero)
                begin
                    status_next = mts_pkg::STAT_POP_EMPTY;
                end
                else
                begin
                    do_pop     = 1'b1;
                    count_next = count_m1;
                    top_next   = below;
                    if (top_reg < min_ext)
                    begin
                        min_next = restored_min[DW-1:0];
                    end
                end
            end
            default:
            begin
                status_next = mts_pkg::STAT_OK;
            end
        endcase
    end

    assign min_next_ext = {{(EW - DW){min_next[DW-1]}}, min_next};

    // Decode the new top: a marker word stands for the minimum itself.
    always_comb
    begin
        if (count_next == '0)
        begin
            top_out = '0;
            min_out = '0;
        end
        else
        begin
            top_out = (top_next >= min_next_ext) ? top_next[DW-1:0] : min_next;
            min_out = min_next;
        end
        out_data_next = {FILL_W_CAST(count_next), (count_next == '0), min_out, top_out};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            min_reg       <= mts_pkg::INT_MAX;
            below_sel_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                count_reg <= count_next;
                min_reg   <= min_next;
                if (do_push)
                begin
                    below_sel_reg <= 1'b0;
                end
                else if (do_pop)
                begin
                    below_sel_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            top_reg        <= top_next;
            out_data_reg   <= out_data_next;
            out_status_reg <= status_next;
            if (do_push)
            begin
                below_reg <= top_reg;
            end
        end
    end

    // The old top moves into the RAM on a push; a pop prefetches the entry
    // that will sit below the new top.
    mts_ram #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (fire && do_push && !is_zero),
        .wr_addr (count_m1[AW-1:0]),
        .wr_data (top_reg),
        .rd_en   (fire && do_pop),
        .rd_addr (count_m3[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    `MTS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(STACK_DEPTH))
    `MTS_ASSERT_NEXT(a_push_grows, fire && do_push, count_reg == CW'($past(count_reg) + 1))
    `MTS_ASSERT_NEXT(a_pop_shrinks, fire && do_pop, count_reg == CW'($past(count_reg) - 1))
    `MTS_ASSERT_IMP(a_full_fill, m_tvalid && (m_tuser == mts_pkg::STAT_PUSH_FULL),
        m_tdata[71:65] == mts_pkg::FILL_W'(STACK_DEPTH))

endmodule

// File: sv/mts_ram.sv
// Entry storage of the min-tracking stack: one write port, one read port
// with registered read data. Depends on mts_pkg for the entry type.
module mts_ram #(
    parameter int DEPTH  = mts_pkg::STACK_DEPTH_DEFAULT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  mts_pkg::entry_t     wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output mts_pkg::entry_t     rd_data
);

    mts_pkg::entry_t mem [DEPTH];
    mts_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: dv/min_tracking_stack_core_tb.sv
// Self-checking testbench for min_tracking_stack_core: a queue-fed stream driver, a result
// monitor and a per-item predictor of the stack, its minimum and its status codes.
// Depends on mts_pkg and the min_tracking_stack_core RTL only.
`timescale 1ns / 100ps

module min_tracking_stack_core_tb;

    localparam int FILL_DEPTH = mts_pkg::STACK_DEPTH_DEFAULT;
    localparam int PLAN_ITEMS = 600;
    localparam int HOLD_CYCLES = 150;

    typedef struct {
        mts_pkg::action_t   act;
        logic signed [31:0] val;
        bit                wait_drain;
    } op_item_t;

    typedef struct {
        logic signed [31:0] top_val;
        logic signed [31:0] min_val;
        logic               empty;
        logic [6:0]         fill;
        mts_pkg::status_t   status;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // value[31:0]
    logic [0:0]  s_tuser = '0;   // action[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // top_value[31:0], min_value[63:32], is_empty[64],
                                 // fill_count[71:65]
    logic [1:0]  m_tuser;        // status[1:0]

    op_item_t op_queue[$];
    result_t  pending_results[$];

    // Predictor state: stored words, fill level and the running minimum.
    mts_pkg::entry_t    stack_words [FILL_DEPTH];
    int                 stack_fill = 0;
    logic signed [31:0] stack_min = mts_pkg::INT_MAX;

    int plan_fill = 0;
    int planned = 0;
    int sent_count = 0;
    int seen_count = 0;
    int err_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    min_tracking_stack_core #(
        .STACK_DEPTH (FILL_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    function automatic result_t predict_min_stack(mts_pkg::action_t act,
                                                  logic signed [31:0] val);
        result_t         r;
        mts_pkg::entry_t word;
        longint          restored;
        r.status = mts_pkg::STAT_OK;
        if (act == mts_pkg::ACT_PUSH)
        begin
            if (stack_fill >= FILL_DEPTH)
                r.status = mts_pkg::STAT_PUSH_FULL;
            else if (stack_fill == 0)
            begin
                stack_words[0] = val;
                stack_min = val;
                stack_fill = 1;
            end
            else if (val >= stack_min)
            begin
                stack_words[stack_fill] = val;
                stack_fill++;
            end
            else
            begin
                // The marker word lies below the new minimum and encodes the old one.
                stack_words[stack_fill] =
                    mts_pkg::entry_t'(2 * longint'(val) - longint'(stack_min));
                stack_min = val;
                stack_fill++;
            end
        end
        else
        begin
            if (stack_fill == 0)
                r.status = mts_pkg::STAT_POP_EMPTY;
            else
            begin
                word = stack_words[stack_fill - 1];
                if (word < stack_min)
                begin
                    restored = 2 * longint'(stack_min) - longint'(word);
                    stack_min = restored[31:0];
                end
                stack_fill--;
            end
        end
        if (stack_fill == 0)
        begin
            r.top_val = '0;
            r.min_val = '0;
            r.empty = 1'b1;
        end
        else
        begin
            word = stack_words[stack_fill - 1];
            r.top_val = (word >= stack_min) ? word[31:0] : stack_min;
            r.min_val = stack_min;
            r.empty = 1'b0;
        end
        r.fill = stack_fill[6:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic add_op(input mts_pkg::action_t act, input logic signed [31:0] val,
                          input bit drain);
        op_item_t item;
        item.act = act;
        item.val = val;
        item.wait_drain = drain;
        op_queue.push_back(item);
        planned++;
        if (act == mts_pkg::ACT_PUSH && plan_fill < FILL_DEPTH)
            plan_fill++;
        else if (act == mts_pkg::ACT_POP && plan_fill > 0)
            plan_fill--;
    endtask

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = $signed($urandom_range(0, 40)) - 20;
            3: v = $urandom_range(0, 1) ? mts_pkg::INT_MAX : -mts_pkg::INT_MAX - 1;
            4: v = -$signed($urandom_range(0, 1000));
            default: v = $urandom_range(0, 1000);
        endcase
        return v;
    endfunction

    // Driver: one item per transfer, predicted at the edge where it is accepted.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        op_item_t nxt;
        bit       steady;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pending_results.push_back(
                    predict_min_stack(mts_pkg::action_t'(s_tuser[0]), $signed(s_tdata)));
                sent_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                steady = (sent_count >= 250 && sent_count < 350);
                if (op_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 36)
                    && !(op_queue[0].wait_drain && pending_results.size() != 0))
                begin
                    nxt = op_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.val;
                    s_tuser <= nxt.act;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        result_t want;
        result_t got;
        bit      steady;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen_count++;
                got.top_val = m_tdata[31:0];
                got.min_val = m_tdata[63:32];
                got.empty = m_tdata[64];
                got.fill = m_tdata[71:65];
                got.status = mts_pkg::status_t'(m_tuser);
                if (pending_results.size() == 0)
                    report_mismatch("result transfer with no prediction outstanding");
                else
                begin
                    want = pending_results.pop_front();
                    if (got.top_val !== want.top_val)
                        report_mismatch($sformatf("result %0d top_value %0d, expected %0d",
                                                  seen_count, got.top_val, want.top_val));
                    if (got.min_val !== want.min_val)
                        report_mismatch($sformatf("result %0d min_value %0d, expected %0d",
                                                  seen_count, got.min_val, want.min_val));
                    if (got.empty !== want.empty)
                        report_mismatch($sformatf("result %0d is_empty %b, expected %b",
                                                  seen_count, got.empty, want.empty));
                    if (got.fill !== want.fill)
                        report_mismatch($sformatf("result %0d fill_count %0d, expected %0d",
                                                  seen_count, got.fill, want.fill));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                  seen_count, got.status, want.status));
                end
            end
            // One long hold-off lets the sender back up into the input side.
            if (!hold_done && seen_count >= 120)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            steady = (seen_count >= 250 && seen_count < 350);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(0, 99) >= 36);
        end
    end

    initial
    begin : stimulus
        int mode;
        int len;
        // Directed part: empty pops, extreme values, equal and lower pushes.
        add_op(mts_pkg::ACT_POP, $urandom, 1'b0);
        add_op(mts_pkg::ACT_PUSH, mts_pkg::INT_MAX, 1'b0);
        add_op(mts_pkg::ACT_PUSH, -mts_pkg::INT_MAX - 1, 1'b0);
        add_op(mts_pkg::ACT_PUSH, -mts_pkg::INT_MAX - 1, 1'b0);
        add_op(mts_pkg::ACT_PUSH, mts_pkg::INT_MAX, 1'b0);
        repeat (4) add_op(mts_pkg::ACT_POP, $urandom, 1'b0);
        add_op(mts_pkg::ACT_POP, $urandom, 1'b0);
        // The minimum is stale after the last pop; this push must replace it.
        add_op(mts_pkg::ACT_PUSH, -1, 1'b1);
        add_op(mts_pkg::ACT_PUSH, 0, 1'b0);
        add_op(mts_pkg::ACT_PUSH, -2, 1'b0);
        add_op(mts_pkg::ACT_PUSH, 32'sh5555_5555, 1'b0);
        add_op(mts_pkg::ACT_PUSH, -7, 1'b0);
        add_op(mts_pkg::ACT_PUSH, 32'shAAAA_AAAA, 1'b0);
        repeat (7) add_op(mts_pkg::ACT_POP, $urandom, 1'b0);

        while (planned < PLAN_ITEMS)
        begin
            mode = $urandom_range(0, 3);
            if (mode == 0)
            begin
                // Climb to a full stack, then push against it.
                while (plan_fill < FILL_DEPTH)
                    add_op(($urandom_range(0, 99) < 15) ? mts_pkg::ACT_POP
                                                        : mts_pkg::ACT_PUSH,
                           pick_value(), 1'b0);
                repeat ($urandom_range(1, 3)) add_op(mts_pkg::ACT_PUSH, pick_value(), 1'b0);
            end
            else if (mode == 1)
            begin
                while (plan_fill > 0)
                    add_op(($urandom_range(0, 99) < 15) ? mts_pkg::ACT_PUSH
                                                        : mts_pkg::ACT_POP,
                           pick_value(), 1'b0);
                repeat ($urandom_range(1, 2)) add_op(mts_pkg::ACT_POP, pick_value(), 1'b0);
            end
            else
            begin
                len = $urandom_range(10, 40);
                repeat (len)
                    add_op(mts_pkg::action_t'($urandom_range(0, 1)), pick_value(), 1'b0);
            end
            if (planned >= 300 && planned < 340)
                add_op(mts_pkg::ACT_PUSH, pick_value(), 1'b1);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() != 0 || s_tvalid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("min_tracking_stack_core_tb passed");
        else
            $display("min_tracking_stack_core_tb failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("min_tracking_stack_core_tb failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/mts_pkg.sv
sv/mts_ram.sv
sv/min_tracking_stack_core.sv
dv/min_tracking_stack_core_tb.sv
